[sv/bppm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bppm_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int AVAIL_W = $clog2(NUM_SLOTS + 1);

  localparam logic [7:0] PIN_MAX = 8'd255;

  localparam logic OP_PIN = 1'b0;
  localparam logic OP_UNPIN = 1'b1;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_ASSIGNED = 3'd1;
  localparam logic [2:0] ST_NOFREE = 3'd2;
  localparam logic [2:0] ST_UNPIN_OK = 3'd3;
  localparam logic [2:0] ST_UNPIN_BAD = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UNPIN,
    S_MATCH,
    S_FREE
  } state_t;

endpackage

`default_nettype wire

[sv/bppm_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bppm_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] file_id;
  logic [31:0] block_num;
  logic [2:0]  slot;

  modport source(output valid, output opcode, output file_id, output block_num,
                 output slot, input ready);
  modport sink(input valid, input opcode, input file_id, input block_num,
               input slot, output ready);
endinterface

interface bppm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  slot_out;
  logic        evicted;
  logic [15:0] evicted_file;
  logic [31:0] evicted_block;
  logic [3:0]  available;

  modport source(output valid, output status, output slot_out, output evicted,
                 output evicted_file, output evicted_block, output available,
                 input ready);
  modport sink(input valid, input status, input slot_out, input evicted,
               input evicted_file, input evicted_block, input available,
               output ready);
endinterface

`default_nettype wire

[sv/buffer_pool_pin_manager.sv]
`timescale 1ns / 1ps
`default_nettype none

// Buffer pool pin manager for eight slots. Each request transfer on req gives exactly
// one response transfer on rsp. One key comparator and one pin-count test are shared
// and stepped over the slots, one slot per cycle: an unpin tests only the named slot,
// a pin that hits slot k stops there, and a pin that misses searches all eight keys
// and then the slots from 0 up to reach the lowest unpinned slot, or reports no free
// slot when every slot is pinned. The block returns to idle to take the next
// request. The response sits in an output register, so the next request is taken
// while a response still waits; a finished item waits only if that register is
// still full.
module buffer_pool_pin_manager (
  input wire logic     clk,
  input wire logic     rst,
  bppm_req_if.sink     req,
  bppm_rsp_if.source   rsp
);

  bppm_pkg::state_t state, state_next;
  logic [bppm_pkg::IDX_W-1:0] idx, idx_next;

  logic [15:0] file_reg;
  logic [31:0] block_reg;
  logic [2:0]  slot_reg;

  logic [bppm_pkg::NUM_SLOTS-1:0] slot_valid;
  logic [15:0] slot_file [bppm_pkg::NUM_SLOTS];
  logic [31:0] slot_block [bppm_pkg::NUM_SLOTS];
  logic [7:0]  pin_count [bppm_pkg::NUM_SLOTS];
  logic [bppm_pkg::AVAIL_W-1:0] avail_count, avail_next;

  logic        out_valid;
  logic [2:0]  out_status;
  logic [2:0]  out_slot;
  logic        out_ev;
  logic [15:0] out_ef;
  logic [31:0] out_eb;
  logic [3:0]  out_avail;

  logic        out_free;
  logic        last;
  logic        key_hit;
  logic        slot_bad;
  logic [7:0]  cnt_cur;
  logic        fin;
  logic        upd_pin;
  logic [7:0]  pin_new;
  logic        set_key;
  logic [2:0]  res_status;
  logic [2:0]  res_slot;
  logic        res_ev;
  logic [15:0] res_ef;
  logic [31:0] res_eb;

  assign out_free = !out_valid || rsp.ready;
  assign last = (idx == bppm_pkg::IDX_W'(bppm_pkg::NUM_SLOTS - 1));
  assign cnt_cur = pin_count[idx];
  assign key_hit = slot_valid[idx] && (slot_file[idx] == file_reg) &&
                   (slot_block[idx] == block_reg);
  assign slot_bad = ({1'b0, slot_reg} >= 4'(bppm_pkg::NUM_SLOTS));

  always_comb begin
    state_next = state;
    idx_next = idx;
    avail_next = avail_count;
    fin = 1'b0;
    upd_pin = 1'b0;
    pin_new = cnt_cur;
    set_key = 1'b0;
    res_status = bppm_pkg::ST_HIT;
    res_slot = 3'd0;
    res_ev = 1'b0;
    res_ef = 16'd0;
    res_eb = 32'd0;
    req.ready = 1'b0;
    case (state)
      bppm_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.opcode == bppm_pkg::OP_UNPIN) begin
            state_next = bppm_pkg::S_UNPIN;
            idx_next = req.slot[bppm_pkg::IDX_W-1:0];
          end else begin
            state_next = bppm_pkg::S_MATCH;
            idx_next = '0;
          end
        end
      end
      bppm_pkg::S_UNPIN: begin
        res_slot = slot_reg;
        if (out_free) begin
          fin = 1'b1;
          state_next = bppm_pkg::S_IDLE;
          if (slot_bad || cnt_cur == 8'd0) begin
            res_status = bppm_pkg::ST_UNPIN_BAD;
          end else begin
            res_status = bppm_pkg::ST_UNPIN_OK;
            upd_pin = 1'b1;
            pin_new = cnt_cur - 8'd1;
            if (cnt_cur == 8'd1) begin
              avail_next = avail_count + 1'b1;
            end
          end
        end
      end
      bppm_pkg::S_MATCH: begin
        res_slot = 3'(idx);
        if (key_hit) begin
          if (out_free) begin
            fin = 1'b1;
            state_next = bppm_pkg::S_IDLE;
            if (cnt_cur == bppm_pkg::PIN_MAX) begin
              res_status = bppm_pkg::ST_FULL;
            end else begin
              res_status = bppm_pkg::ST_HIT;
              upd_pin = 1'b1;
              pin_new = cnt_cur + 8'd1;
              if (cnt_cur == 8'd0 && avail_count != '0) begin
                avail_next = avail_count - 1'b1;
              end
            end
          end
        end else if (last) begin
          idx_next = '0;
          state_next = bppm_pkg::S_FREE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      bppm_pkg::S_FREE: begin
        if (cnt_cur == 8'd0) begin
          res_status = bppm_pkg::ST_ASSIGNED;
          res_slot = 3'(idx);
          res_ev = slot_valid[idx];
          res_ef = slot_valid[idx] ? slot_file[idx] : 16'd0;
          res_eb = slot_valid[idx] ? slot_block[idx] : 32'd0;
          if (out_free) begin
            fin = 1'b1;
            state_next = bppm_pkg::S_IDLE;
            set_key = 1'b1;
            upd_pin = 1'b1;
            pin_new = 8'd1;
            if (avail_count != '0) begin
              avail_next = avail_count - 1'b1;
            end
          end
        end else if (last) begin
          res_status = bppm_pkg::ST_NOFREE;
          if (out_free) begin
            fin = 1'b1;
            state_next = bppm_pkg::S_IDLE;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = bppm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bppm_pkg::S_IDLE;
      idx <= '0;
      slot_valid <= '0;
      avail_count <= bppm_pkg::AVAIL_W'(bppm_pkg::NUM_SLOTS);
      out_valid <= 1'b0;
      for (int i = 0; i < bppm_pkg::NUM_SLOTS; i++) begin
        pin_count[i] <= 8'd0;
      end
    end else begin
      state <= state_next;
      idx <= idx_next;
      avail_count <= avail_next;
      if (upd_pin) begin
        pin_count[idx] <= pin_new;
      end
      if (set_key) begin
        slot_valid[idx] <= 1'b1;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      file_reg <= req.file_id;
      block_reg <= req.block_num;
      slot_reg <= req.slot;
    end
    if (set_key) begin
      slot_file[idx] <= file_reg;
      slot_block[idx] <= block_reg;
    end
    if (fin) begin
      out_status <= res_status;
      out_slot <= res_slot;
      out_ev <= res_ev;
      out_ef <= res_ef;
      out_eb <= res_eb;
      out_avail <= 4'(avail_next);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.slot_out = out_slot;
  assign rsp.evicted = out_ev;
  assign rsp.evicted_file = out_ef;
  assign rsp.evicted_block = out_eb;
  assign rsp.available = out_avail;

  logic [bppm_pkg::NUM_SLOTS-1:0] pin_zero;

  always_comb begin
    for (int i = 0; i < bppm_pkg::NUM_SLOTS; i++) begin
      pin_zero[i] = (pin_count[i] == 8'd0);
    end
  end

`ifndef ASSERT_OFF
  // The running count must track the number of slots with no pins.
  a_avail_matches: assert property (@(posedge clk) disable iff (rst)
    32'(avail_count) == $countones(pin_zero))
    else $error("available count differs from unpinned slot count");

  // A fresh hit response names a slot that now holds at least one pin.
  a_hit_pinned: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && out_status == bppm_pkg::ST_HIT |-> pin_count[out_slot] != 8'd0)
    else $error("pin hit left slot unpinned");

  // No free slot is reported only when every slot is pinned.
  a_nofree_all_pinned: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && out_status == bppm_pkg::ST_NOFREE |-> pin_zero == '0)
    else $error("no free slot reported while a slot is unpinned");

  // An assigned slot becomes valid with the new key.
  a_assign_key: assert property (@(posedge clk) disable iff (rst)
    set_key |=> slot_valid[$past(idx)] && slot_file[$past(idx)] == $past(file_reg))
    else $error("assigned slot does not hold the new key");
`endif

endmodule

`default_nettype wire
